[src/sspq_pkg.sv]
`default_nettype none

package sspq_pkg;

    // Field widths fixed by the stream format
    localparam int PRIO_W      = 16;
    localparam int ELEM_W      = 32;
    localparam int COUNT_W     = 5;
    localparam int ERR_W       = 2;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 56;

    // Defaults for the top-level parameters
    localparam int DEF_DEPTH         = 16;
    localparam int DEF_ELEMENT_WIDTH = 32;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } t_err;

    // Broadcast to every cell: at most one of the two is set per cycle
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

`default_nettype wire

[src/sspq_cell.sv]
`default_nettype none

module sspq_cell
    import sspq_pkg::*;
#(
    parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
    input  wire                            i_clk,
    input  t_cell_ctl                      i_ctl,
    input  wire                            i_occ,
    input  wire signed [PRIO_W-1:0]        i_new_prio,
    input  wire        [ELEMENT_WIDTH-1:0] i_new_elem,
    input  wire                            i_prev_ins,
    input  wire signed [PRIO_W-1:0]        i_prev_prio,
    input  wire        [ELEMENT_WIDTH-1:0] i_prev_elem,
    input  wire signed [PRIO_W-1:0]        i_next_prio,
    input  wire        [ELEMENT_WIDTH-1:0] i_next_elem,
    output logic                           o_ins_here,
    output logic signed [PRIO_W-1:0]       o_prio,
    output logic       [ELEMENT_WIDTH-1:0] o_elem,
    output logic signed [PRIO_W-1:0]       o_nxt_prio,
    output logic       [ELEMENT_WIDTH-1:0] o_nxt_elem
);

    logic signed [PRIO_W-1:0]        r_prio;
    logic        [ELEMENT_WIDTH-1:0] r_elem;

    // New entry belongs at or before this slot: slot empty or strictly lower priority
    assign o_ins_here = !i_occ || (i_new_prio > r_prio);
    assign o_prio     = r_prio;
    assign o_elem     = r_elem;

    always_comb begin
        o_nxt_prio = r_prio;
        o_nxt_elem = r_elem;
        if (i_ctl.rem) begin
            // advance toward the head
            o_nxt_prio = i_next_prio;
            o_nxt_elem = i_next_elem;
        end else if (i_ctl.ins) begin
            if (i_prev_ins) begin
                // shift back behind the new entry
                o_nxt_prio = i_prev_prio;
                o_nxt_elem = i_prev_elem;
            end else if (o_ins_here) begin
                o_nxt_prio = i_new_prio;
                o_nxt_elem = i_new_elem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= o_nxt_prio;
        r_elem <= o_nxt_elem;
    end

endmodule

`default_nettype wire

[src/stable_sorted_priority_queue_unit.sv]
// Channel   Dir  Handshake                        Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tuser: command; tdata: priority, element
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata: head, priority, empty, count, error
//
// One beat per cycle while m_axis does not stall: every accepted command updates the whole row of cells
// in the same cycle, each cell comparing the new priority in parallel.
// The result beat sits in an output register; a new command is taken while
// that register is empty or is being drained in the same cycle.
// Reset empties the queue (count only) and clears the result valid; cell contents stay undefined.
// A stall on m_axis holds the result and back-pressures s_axis.
`default_nettype none

module stable_sorted_priority_queue_unit
    import sspq_pkg::*;
#(
    parameter int DEPTH         = DEF_DEPTH,
    parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // slave side
    input  wire                   i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  wire [IN_DATA_W-1:0]   i_s_axis_tdata,  // [15:0] priority_req, [47:16] element
    input  wire                   i_s_axis_tuser,  // [0] command
    // master side
    output logic                  o_m_axis_tvalid,
    input  wire                   i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata   // [31:0] head_element,
                                                   // [47:32] head_priority,
                                                   // [48] is_empty, [53:49] count,
                                                   // [55:54] error
);

    localparam int CW = $clog2(DEPTH + 1);

    // Input beat fields
    t_cmd                      w_cmd;
    logic signed [PRIO_W-1:0]  w_new_prio;
    logic [ELEMENT_WIDTH-1:0]  w_new_elem;

    assign w_cmd      = t_cmd'(i_s_axis_tuser);
    assign w_new_prio = i_s_axis_tdata[PRIO_W-1:0];
    assign w_new_elem = ELEMENT_WIDTH'(i_s_axis_tdata[PRIO_W+ELEM_W-1:PRIO_W]);

    // Control state
    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic   w_accept, w_full, w_empty;
    t_err   w_err;
    t_cell_ctl w_ctl;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_full          = (r_count == CW'(DEPTH));
    assign w_empty         = (r_count == '0);

    always_comb begin
        w_ctl   = '0;
        w_err   = ERR_OK;
        n_count = r_count;
        if (w_accept) begin
            case (w_cmd)
                CMD_INSERT: begin
                    if (w_full) begin
                        w_err = ERR_FULL;           // drop the entry
                    end else begin
                        w_ctl.ins = 1'b1;
                        n_count   = r_count + 1'b1;
                    end
                end
                CMD_REMOVE: begin
                    if (w_empty) begin
                        w_err = ERR_EMPTY;
                    end else begin
                        w_ctl.rem = 1'b1;
                        n_count   = r_count - 1'b1;
                    end
                end
                default: w_err = ERR_OK;
            endcase
        end
    end

    // Row of cells, slot 0 is the head
    logic                     w_ins  [DEPTH];
    logic signed [PRIO_W-1:0] w_prio [DEPTH];
    logic [ELEMENT_WIDTH-1:0] w_elem [DEPTH];
    logic signed [PRIO_W-1:0] w_nprio[DEPTH];
    logic [ELEMENT_WIDTH-1:0] w_nelem[DEPTH];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic                     w_prev_ins;
            logic signed [PRIO_W-1:0] w_prev_prio, w_next_prio;
            logic [ELEMENT_WIDTH-1:0] w_prev_elem, w_next_elem;

            if (g == 0) begin : g_head
                assign w_prev_ins  = 1'b0;
                assign w_prev_prio = '0;
                assign w_prev_elem = '0;
            end else begin : g_body
                assign w_prev_ins  = w_ins[g-1];
                assign w_prev_prio = w_prio[g-1];
                assign w_prev_elem = w_elem[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign w_next_prio = '0;
                assign w_next_elem = '0;
            end else begin : g_mid
                assign w_next_prio = w_prio[g+1];
                assign w_next_elem = w_elem[g+1];
            end

            sspq_cell #(
                .ELEMENT_WIDTH(ELEMENT_WIDTH)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_occ       (CW'(g) < r_count),
                .i_new_prio  (w_new_prio),
                .i_new_elem  (w_new_elem),
                .i_prev_ins  (w_prev_ins),
                .i_prev_prio (w_prev_prio),
                .i_prev_elem (w_prev_elem),
                .i_next_prio (w_next_prio),
                .i_next_elem (w_next_elem),
                .o_ins_here  (w_ins[g]),
                .o_prio      (w_prio[g]),
                .o_elem      (w_elem[g]),
                .o_nxt_prio  (w_nprio[g]),
                .o_nxt_elem  (w_nelem[g])
            );
        end
    endgenerate

    // Result beat from the post-step head
    logic                  w_res_empty;
    logic [ELEM_W-1:0]     w_head_elem;
    logic [PRIO_W-1:0]     w_head_prio;

    assign w_res_empty = (n_count == '0);
    assign w_head_elem = w_res_empty ? '0 : ELEM_W'(w_nelem[0]);
    assign w_head_prio = w_res_empty ? '0 : w_nprio[0];

    always_comb begin
        n_out_data = {w_err, COUNT_W'(n_count), w_res_empty, w_head_prio, w_head_elem};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count above depth");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[55:54] == ERR_FULL) |-> (r_out_data[53:49] == COUNT_W'(DEPTH)))
        else $error("full error reported with queue not full");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[48] == (r_out_data[53:49] == '0) || CW > COUNT_W))
        else $error("empty flag disagrees with count");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.ins) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the queue");

    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.rem) |=> (r_count == $past(r_count) - 1'b1))
        else $error("remove did not shrink the queue");

endmodule

`default_nettype wire
